[rtl/push_pop_trace_classifier_core_assert.svh]
// ----------------------------------------------------------------------------
// push_pop_trace_classifier_core_assert
// Assertion macros for the trace classifier.
// ----------------------------------------------------------------------------
`ifndef PUSH_POP_TRACE_CLASSIFIER_CORE_ASSERT_SVH
`define PUSH_POP_TRACE_CLASSIFIER_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define PPTC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define PPTC_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

[rtl/pptc_pkg.sv]
// ----------------------------------------------------------------------------
// pptc_pkg
// Shared types and codes of the push/pop trace classifier.
// ----------------------------------------------------------------------------
package pptc_pkg;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [2:0] {
		VERDICT_IMPOSSIBLE = 3'd0,
		VERDICT_PRIORITY   = 3'd1,
		VERDICT_QUEUE      = 3'd2,
		VERDICT_STACK      = 3'd3,
		VERDICT_NOT_SURE   = 3'd4
	} verdict_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POP_RD,    // read stack top, fifo head, heap root and heap last
		ST_POP_CHK,   // compare and start the sift down
		ST_DN_RD,     // read both children
		ST_DN_CMP,    // pick the larger child and decide
		ST_UP_RD,     // read the parent
		ST_UP_CMP,    // compare with the parent
		ST_FINISH     // emit verdict if asked
	} state_t;

endpackage

[rtl/push_pop_trace_classifier_core.sv]
// ----------------------------------------------------------------------------
// push_pop_trace_classifier_core
// Mirrors a push/pop trace in a stack, a queue and a max-heap and classifies it.
// ----------------------------------------------------------------------------
// A word is accepted when start is high and busy is low. operation selects a
// push of value or a pop that claims value. When case_end is set, the word is
// carried out and then a verdict word is shown on verdict and overflowed for
// one cycle with result_valid high, and all state returns to its reset values.
// Words without case_end produce no result.
// A push runs ST_UP_RD and ST_UP_CMP per heap level until the new element
// stops rising, then ST_FINISH; a pop runs ST_POP_RD, ST_POP_CHK, then ST_DN_RD
// and ST_DN_CMP per heap level until the moved element settles, then ST_FINISH.
// The element moves at most log2(CAPACITY) heap levels; each level costs one
// synchronous read of the heap memory and one compare. A push onto a full block
// or a pop of an empty block goes straight from ST_IDLE to ST_FINISH.
// Stack and queue entries are read and written once per word.
// Reset clears counters and flags at once; memory contents are never cleared
// because an entry is only read after it is written. The receiver cannot
// stall: each verdict appears for exactly one cycle, after which busy falls.
// ----------------------------------------------------------------------------
module push_pop_trace_classifier_core #(
	parameter int CAPACITY   = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [31:0] value,
	input  logic        case_end,
	output logic        result_valid,
	output logic [2:0]  verdict,
	output logic        overflowed
);
	import pptc_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [VALUE_BITS-1:0] stack_mem [CAPACITY];
	logic [VALUE_BITS-1:0] fifo_mem  [CAPACITY];
	logic [VALUE_BITS-1:0] heap_mem  [CAPACITY];

	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q, tail_q;
	logic could_stack_q, could_fifo_q, could_heap_q, ovf_q;
	logic [VALUE_BITS-1:0] val_q, last_q;
	logic end_q;
	logic [CW-1:0] idx_q, size_q;   // heap position and heap size (wide for 2i+1)
	logic [CW:0] child_q;

	// memory ports
	logic [AW-1:0] stack_ra, fifo_ra, heap_ra, heap_rb;
	logic [VALUE_BITS-1:0] stack_rd, fifo_rd, heap_rda, heap_rdb;
	logic heap_we;
	logic [AW-1:0] heap_wa;
	logic [VALUE_BITS-1:0] heap_wd;
	logic lin_we;

	always_ff @(posedge clk) begin
		if (lin_we) begin
			stack_mem[count_q[AW-1:0]] <= val_q;
			fifo_mem[tail_q] <= val_q;
		end
		if (heap_we)
			heap_mem[heap_wa] <= heap_wd;
		stack_rd <= stack_mem[stack_ra];
		fifo_rd  <= fifo_mem[fifo_ra];
		heap_rda <= heap_mem[heap_ra];
		heap_rdb <= heap_mem[heap_rb];
	end

	logic [CW:0] c1, c2;
	logic [CW-1:0] parent;
	logic [AW-1:0] tail_nx, head_nx;
	logic [1:0] n_flags;

	assign c1 = {idx_q, 1'b1};
	assign c2 = {idx_q, 1'b0} + (CW+1)'(2);
	assign parent = (idx_q - CW'(1)) >> 1;
	assign tail_nx = (tail_q == AW'(CAPACITY - 1)) ? '0 : tail_q + AW'(1);
	assign head_nx = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
	assign n_flags = 2'(could_stack_q) + 2'(could_fifo_q) + 2'(could_heap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Datapath registers and flags.
	logic right_bigger;
	logic [VALUE_BITS-1:0] big_val;
	logic [CW:0] big_idx;
	always_comb begin
		right_bigger = (c2 < (CW+1)'(size_q)) && (heap_rdb > heap_rda);
		big_val = right_bigger ? heap_rdb : heap_rda;
		big_idx = right_bigger ? c2 : c1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			could_stack_q <= 1'b1;
			could_fifo_q <= 1'b1;
			could_heap_q <= 1'b1;
			ovf_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_POP_RD: ;
				ST_POP_CHK: begin
					if (stack_rd != val_q) could_stack_q <= 1'b0;
					if (fifo_rd != val_q) could_fifo_q <= 1'b0;
					if (heap_rda != val_q) could_heap_q <= 1'b0;
					head_q <= head_nx;
					count_q <= count_q - CW'(1);
				end
				ST_FINISH: begin
					if (end_q) begin
						count_q <= '0;
						head_q <= '0;
						tail_q <= '0;
						could_stack_q <= 1'b1;
						could_fifo_q <= 1'b1;
						could_heap_q <= 1'b1;
						ovf_q <= 1'b0;
					end
				end
				default: ;
			endcase
			if (state_q == ST_IDLE && start) begin
				if (operation == OP_PUSH) begin
					if (count_q >= CAP_C) ovf_q <= 1'b1;
				end else if (count_q == '0) begin
					could_stack_q <= 1'b0;
					could_fifo_q <= 1'b0;
					could_heap_q <= 1'b0;
				end
			end
			if (lin_we) begin
				tail_q <= tail_nx;
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			val_q <= VALUE_BITS'(value);
			end_q <= case_end;
			idx_q <= count_q;
			size_q <= count_q - CW'(1);
		end
		if (state_q == ST_POP_CHK) begin
			last_q <= heap_rdb;
			idx_q <= '0;
		end
		if (state_q == ST_DN_CMP)
			idx_q <= big_idx[CW-1:0];
		if (state_q == ST_UP_CMP)
			idx_q <= parent;
	end

	always_comb begin
		state_d = state_q;
		busy = (state_q != ST_IDLE);
		stack_ra = count_q[AW-1:0] - AW'(1);
		fifo_ra = head_q;
		heap_ra = '0;
		heap_rb = AW'(count_q - CW'(1));
		heap_we = 1'b0;
		heap_wa = idx_q[AW-1:0];
		heap_wd = val_q;
		lin_we = 1'b0;
		result_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (operation == OP_PUSH)
						state_d = (count_q >= CAP_C) ? ST_FINISH : ST_UP_RD;
					else
						state_d = (count_q == '0) ? ST_FINISH : ST_POP_RD;
				end
			end
			ST_POP_RD: state_d = ST_POP_CHK;
			ST_POP_CHK: state_d = (size_q > CW'(1)) ? ST_DN_RD : ST_DN_CMP;
			ST_DN_RD: begin
				heap_ra = c1[AW-1:0];
				heap_rb = (c2 < (CW+1)'(CAPACITY)) ? c2[AW-1:0] : c1[AW-1:0];
				if (c1 >= (CW+1)'(size_q)) begin
					heap_we = (size_q != '0);
					heap_wd = last_q;
					state_d = ST_FINISH;
				end else
					state_d = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				// Reached also straight from the check when at most one element remains.
				if (size_q <= CW'(1)) begin
					heap_we = (size_q != '0);
					heap_wd = last_q;
					heap_wa = '0;
					state_d = ST_FINISH;
				end else if (big_val > last_q) begin
					heap_we = 1'b1;
					heap_wd = big_val;
					state_d = ST_DN_RD;
				end else begin
					heap_we = 1'b1;
					heap_wd = last_q;
					state_d = ST_FINISH;
				end
			end
			ST_UP_RD: begin
				heap_ra = parent[AW-1:0];
				if (idx_q == '0) begin
					heap_we = 1'b1;
					lin_we = 1'b1;
					state_d = ST_FINISH;
				end else
					state_d = ST_UP_CMP;
			end
			ST_UP_CMP: begin
				if (heap_rda >= val_q) begin
					heap_we = 1'b1;
					lin_we = 1'b1;
					state_d = ST_FINISH;
				end else begin
					heap_we = 1'b1;
					heap_wd = heap_rda;
					state_d = ST_UP_RD;
				end
			end
			ST_FINISH: begin
				result_valid = end_q;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		if (n_flags == 2'd0) verdict = VERDICT_IMPOSSIBLE;
		else if (n_flags > 2'd1) verdict = VERDICT_NOT_SURE;
		else if (could_heap_q) verdict = VERDICT_PRIORITY;
		else if (could_fifo_q) verdict = VERDICT_QUEUE;
		else verdict = VERDICT_STACK;
	end
	assign overflowed = ovf_q;

	`include "push_pop_trace_classifier_core_assert.svh"

	`PPTC_ASSERT(a_count_bound, clk, arst_n, count_q <= CAP_C, "element count beyond capacity")
	`PPTC_ASSERT(a_result_finish, clk, arst_n, !result_valid || state_q == ST_FINISH, "stray result")
	`PPTC_ASSERT_NEXT(a_result_idle, clk, arst_n, result_valid, !busy && count_q == '0, "no reset after verdict")

endmodule
